/* sv/md4_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md4_pkg
// Shared constants, round tables and controller/datapath handshake types
// for the MD4 hash engine.
// ----------------------------------------------------------------------------
package md4_pkg;

    localparam logic [31:0] IV0      = 32'h67452301;
    localparam logic [31:0] IV1      = 32'hefcdab89;
    localparam logic [31:0] IV2      = 32'h98badcfe;
    localparam logic [31:0] IV3      = 32'h10325476;
    localparam logic [31:0] RK2      = 32'h5A827999;
    localparam logic [31:0] RK3      = 32'h6ED9EBA1;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  OFS_MASK = 6'h3f;
    localparam logic [5:0]  LEN_OFS  = 6'd56;
    localparam logic [5:0]  LAST_RND = 6'd47;
    localparam logic [2:0]  MAX_BYTES = 3'd4;

    localparam logic [1:0]  GRP_F = 2'd0;
    localparam logic [1:0]  GRP_G = 2'd1;
    localparam logic [1:0]  GRP_H = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic       load;       // capture an input beat
        logic       wr_step;    // place pending bytes into the block
        logic       pad;        // 0x80, zero fill, length if it fits
        logic       len_blk;    // extra block: zeros then length
        logic       round_en;   // one compression round
        logic [5:0] round;
        logic       chain_add;
        logic       restart;    // back to IV, byte count cleared
        logic [1:0] out_sel;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic rem_zero;
        logic wr_full;
        logic pad_wrap;
    } sts_t;

    // message word used by round j
    function automatic logic [3:0] msg_idx(input logic [5:0] j);
        logic [3:0] i;
        logic [3:0] r;
        i = j[3:0];
        unique case (j[5:4])
            GRP_F:   r = i;
            GRP_G:   r = {i[1:0], i[3:2]};
            default: r = {i[0], i[1], i[2], i[3]};
        endcase
        return r;
    endfunction

    function automatic logic [4:0] rot_amt(input logic [5:0] j);
        logic [4:0] s;
        unique case ({j[5:4], j[1:0]})
            4'b0000: s = 5'd3;
            4'b0001: s = 5'd7;
            4'b0010: s = 5'd11;
            4'b0011: s = 5'd19;
            4'b0100: s = 5'd3;
            4'b0101: s = 5'd5;
            4'b0110: s = 5'd9;
            4'b0111: s = 5'd13;
            4'b1000: s = 5'd3;
            4'b1001: s = 5'd9;
            4'b1010: s = 5'd11;
            4'b1011: s = 5'd15;
            default: s = 5'd3;
        endcase
        return s;
    endfunction

endpackage

/* sv/md4_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md4_in_if
// Message word channel: valid/ready with data word, byte count, final flag.
// ----------------------------------------------------------------------------
interface md4_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        final_word;

    modport source (output valid, output data_word, output valid_bytes,
                    output final_word, input ready);
    modport sink   (input valid, input data_word, input valid_bytes,
                    input final_word, output ready);
endinterface

/* sv/md4_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md4_out_if
// Digest channel: valid/ready with one digest word per beat.
// ----------------------------------------------------------------------------
interface md4_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        digest_end;

    modport source (output valid, output digest_word, output word_index,
                    output digest_end, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input digest_end, output ready);
endinterface

/* sv/md4_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md4_dpath
// Block buffer with byte lanes, byte counter, chaining words and the
// single-round MD4 compression unit.
// ----------------------------------------------------------------------------
module md4_dpath (
    input  logic          clk,
    input  logic          rst_n,
    input  md4_pkg::cmd_t cmd,
    output md4_pkg::sts_t sts,
    input  logic [31:0]   data_word,
    input  logic [2:0]    valid_bytes,
    output logic [31:0]   digest_word
);
    import md4_pkg::*;

    logic [31:0]  chain_reg [4];
    logic [31:0]  chain_next [4];
    logic [31:0]  work_reg [4];
    logic [31:0]  work_next [4];
    logic [31:0]  blk_reg [16];
    logic [63:0]  total_reg, total_next;
    logic [31:0]  pend_reg, pend_next;
    logic [2:0]   rem_reg, rem_next;

    logic [5:0]   off;
    logic [6:0]   room;
    logic [2:0]   k;
    logic [63:0]  len_bits;
    logic [63:0]  byte_we;
    logic [511:0] byte_wd;

    logic [3:0]   widx;
    logic [31:0]  xw, f, kc, sum, rnd_out;
    logic [63:0]  dbl;

    assign off      = total_reg[5:0] & OFS_MASK;
    assign room     = 7'd64 - {1'b0, off};
    assign k        = ({4'b0, rem_reg} <= room) ? rem_reg : room[2:0];
    assign len_bits = {total_reg[60:0], 3'b000};

    assign sts.rem_zero = (rem_reg == 3'd0);
    assign sts.wr_full  = (({1'b0, off} + {4'b0, k}) == 7'd64);
    assign sts.pad_wrap = (off >= LEN_OFS);

    assign digest_word = chain_reg[cmd.out_sel];

    // byte lane write enables and data for the 64-byte block
    always_comb
    begin
        logic [5:0]  pos;
        logic [5:0]  d;
        logic [31:0] psh;
        logic [63:0] lsh;
        byte_we = '0;
        byte_wd = '0;
        for (int p = 0; p < 64; p++)
        begin
            pos = 6'(p);
            d   = pos - off;
            psh = pend_reg >> {d[1:0], 3'b000};
            lsh = len_bits >> {pos[2:0], 3'b000};
            if (cmd.wr_step && (d < {3'b000, k}))
            begin
                byte_we[p] = 1'b1;
                byte_wd[p*8 +: 8] = psh[7:0];
            end
            else if (cmd.pad)
            begin
                if ((pos >= LEN_OFS) && (off < LEN_OFS))
                begin
                    byte_we[p] = 1'b1;
                    byte_wd[p*8 +: 8] = lsh[7:0];
                end
                else if (pos == off)
                begin
                    byte_we[p] = 1'b1;
                    byte_wd[p*8 +: 8] = PAD_BYTE;
                end
                else if (pos > off)
                begin
                    byte_we[p] = 1'b1;
                end
            end
            else if (cmd.len_blk)
            begin
                byte_we[p] = 1'b1;
                if (pos >= LEN_OFS)
                    byte_wd[p*8 +: 8] = lsh[7:0];
            end
        end
    end

    // one MD4 round; registers rotate so the target is always word 0
    always_comb
    begin
        widx = msg_idx(cmd.round);
        xw   = blk_reg[widx];
        unique case (cmd.round[5:4])
            GRP_F:
            begin
                f  = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
                kc = '0;
            end
            GRP_G:
            begin
                f  = (work_reg[1] & work_reg[2]) | (work_reg[1] & work_reg[3])
                   | (work_reg[2] & work_reg[3]);
                kc = RK2;
            end
            GRP_H:
            begin
                f  = work_reg[1] ^ work_reg[2] ^ work_reg[3];
                kc = RK3;
            end
            default:
            begin
                f  = '0;
                kc = '0;
            end
        endcase
        sum     = work_reg[0] + f + xw + kc;
        dbl     = {sum, sum} << rot_amt(cmd.round);
        rnd_out = dbl[63:32];
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            chain_next[i] = cmd.chain_add ? chain_reg[i] + work_reg[i] : chain_reg[i];
        if (cmd.restart)
        begin
            chain_next[0] = IV0;
            chain_next[1] = IV1;
            chain_next[2] = IV2;
            chain_next[3] = IV3;
        end
        if (cmd.round_en)
        begin
            work_next[0] = work_reg[3];
            work_next[1] = rnd_out;
            work_next[2] = work_reg[1];
            work_next[3] = work_reg[2];
        end
        else
        begin
            for (int i = 0; i < 4; i++)
                work_next[i] = chain_next[i];
        end

        total_next = total_reg;
        pend_next  = pend_reg;
        rem_next   = rem_reg;
        if (cmd.restart)
            total_next = '0;
        if (cmd.load)
        begin
            pend_next = data_word;
            rem_next  = (valid_bytes > MAX_BYTES) ? MAX_BYTES : valid_bytes;
        end
        else if (cmd.wr_step)
        begin
            pend_next  = pend_reg >> {k, 3'b000};
            rem_next   = rem_reg - k;
            total_next = total_reg + {61'b0, k};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= IV0;
            chain_reg[1] <= IV1;
            chain_reg[2] <= IV2;
            chain_reg[3] <= IV3;
            total_reg    <= '0;
            rem_reg      <= '0;
        end
        else
        begin
            chain_reg <= chain_next;
            total_reg <= total_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        pend_reg <= pend_next;
        for (int w = 0; w < 16; w++)
        begin
            for (int b = 0; b < 4; b++)
            begin
                if (byte_we[w*4 + b])
                    blk_reg[w][b*8 +: 8] <= byte_wd[(w*4 + b)*8 +: 8];
            end
        end
    end

endmodule

/* sv/md4_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md4_ctrl
// Sequencer: word intake, byte placement, padding, 48-round compression
// and the four-beat digest output.
// ----------------------------------------------------------------------------
module md4_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_final,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    out_index,
    output logic          out_end,
    output md4_pkg::cmd_t cmd,
    input  md4_pkg::sts_t sts
);
    import md4_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_PAD,
        S_LEN,
        S_COMP,
        S_ADD,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        A_WRITE,
        A_LEN,
        A_EMIT
    } after_t;

    state_t     state_reg;
    after_t     after_reg;
    logic [5:0] rnd_reg;
    logic [1:0] idx_reg;
    logic       fin_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT);
    assign out_index = idx_reg;
    assign out_end   = (idx_reg == 2'd3);

    always_comb
    begin
        cmd          = '0;
        cmd.round    = rnd_reg;
        cmd.out_sel  = idx_reg;
        unique case (state_reg)
            S_IDLE:  cmd.load      = in_valid;
            S_WRITE: cmd.wr_step   = !sts.rem_zero;
            S_PAD:   cmd.pad       = 1'b1;
            S_LEN:   cmd.len_blk   = 1'b1;
            S_COMP:  cmd.round_en  = 1'b1;
            S_ADD:   cmd.chain_add = 1'b1;
            S_EMIT:  cmd.restart   = out_ready && (idx_reg == 2'd3);
            default: cmd.load      = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            after_reg <= A_WRITE;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        fin_reg   <= in_final;
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    // a full block goes to compression, then the rest of the word
                    if (!sts.rem_zero && sts.wr_full)
                    begin
                        rnd_reg   <= '0;
                        after_reg <= A_WRITE;
                        state_reg <= S_COMP;
                    end
                    else
                    begin
                        state_reg <= fin_reg ? S_PAD : S_IDLE;
                    end
                end
                S_PAD:
                begin
                    rnd_reg   <= '0;
                    after_reg <= sts.pad_wrap ? A_LEN : A_EMIT;
                    state_reg <= S_COMP;
                end
                S_LEN:
                begin
                    rnd_reg   <= '0;
                    after_reg <= A_EMIT;
                    state_reg <= S_COMP;
                end
                S_COMP:
                begin
                    if (rnd_reg == LAST_RND)
                        state_reg <= S_ADD;
                    else
                        rnd_reg <= rnd_reg + 6'd1;
                end
                S_ADD:
                begin
                    unique case (after_reg)
                        A_WRITE: state_reg <= S_WRITE;
                        A_LEN:   state_reg <= S_LEN;
                        A_EMIT:
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_EMIT;
                        end
                        default: state_reg <= S_WRITE;
                    endcase
                end
                S_EMIT:
                begin
                    if (out_ready)
                    begin
                        idx_reg <= idx_reg + 2'd1;
                        if (idx_reg == 2'd3)
                        begin
                            fin_reg   <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* sv/md4_hash_engine.sv */
`timescale 1ns / 1ps
// Sequence: a word is accepted, then its bytes are placed; a word that fills
//   the 64-byte block adds 48 rounds, the chain add and a resume.
// Final word: padding and compression, plus a length block when the offset
//   is 56 or more, then four digest beats. On long messages the rate is set
//   by the one-round-per-cycle compression unit.
// Reset: asynchronous, active low; chaining words to IV, byte count cleared.
// ----------------------------------------------------------------------------
// md4_hash_engine
// Streaming MD4 digest engine: message words in, four digest words out.
// ----------------------------------------------------------------------------
module md4_hash_engine (
    input  logic      clk,
    input  logic      rst_n,
    md4_in_if.sink    msg,
    md4_out_if.source digest
);
    import md4_pkg::*;

    cmd_t cmd;
    sts_t sts;

    md4_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (msg.valid),
        .in_final  (msg.final_word),
        .in_ready  (msg.ready),
        .out_valid (digest.valid),
        .out_ready (digest.ready),
        .out_index (digest.word_index),
        .out_end   (digest.digest_end),
        .cmd       (cmd),
        .sts       (sts)
    );

    md4_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .data_word   (msg.data_word),
        .valid_bytes (msg.valid_bytes),
        .digest_word (digest.digest_word)
    );

endmodule

/* sv/md4_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md4_chk
// Port-level checks for the MD4 engine, bound to the top level.
// ----------------------------------------------------------------------------
module md4_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        msg_valid,
    input logic        msg_ready,
    input logic        dig_valid,
    input logic        dig_ready,
    input logic [31:0] dig_word,
    input logic [1:0]  dig_index,
    input logic        dig_end
);

    // stalled digest beat holds
    a_dig_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid && !dig_ready |=> dig_valid && $stable(dig_word)
                                    && $stable(dig_index))
        else $error("digest beat changed while stalled");

    // end flag marks the fourth word only
    a_end_idx: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid |-> (dig_end == (dig_index == 2'd3)))
        else $error("digest_end not on word 3");

    // digest words follow back to back in order
    a_idx_seq: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid && dig_ready && !dig_end |=>
            dig_valid && (dig_index == $past(dig_index) + 2'd1))
        else $error("digest word sequence broken");

    // no intake while a digest is out, nor right after a beat is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (dig_valid || $past(msg_valid && msg_ready)) |-> !msg_ready)
        else $error("input taken while busy");

endmodule

bind md4_hash_engine md4_chk u_md4_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .msg_valid (msg.valid),
    .msg_ready (msg.ready),
    .dig_valid (digest.valid),
    .dig_ready (digest.ready),
    .dig_word  (digest.digest_word),
    .dig_index (digest.word_index),
    .dig_end   (digest.digest_end)
);

/* tb/md4_digest_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md4_digest_checker
// Watches the message and digest channels of the MD4 engine. Every accepted
// message beat is folded into a local MD4 model; a final beat queues the four
// digest words it must produce, and each accepted digest beat is compared,
// field by field, with the oldest queued word.
// ----------------------------------------------------------------------------
module md4_digest_checker (
    input  logic clk,
    input  logic rst_n,
    md4_in_if    msg,
    md4_out_if   digest,
    output int   errors,
    output int   pending
);

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  index;
        logic        last;
    } digest_beat_t;

    digest_beat_t digest_due[$];
    digest_beat_t due;

    logic [31:0] chain_st [4];
    logic [31:0] block_st [16];
    logic [63:0] msg_bytes;

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // message word schedule: straight, column-major, bit-reversed
    function automatic logic [3:0] word_for_round(input int j);
        logic [3:0] i;
        i = 4'(j % 16);
        if (j < 16)
            return i;
        if (j < 32)
            return {i[1:0], i[3:2]};
        return {i[0], i[1], i[2], i[3]};
    endfunction

    function automatic logic [4:0] shift_for_round(input int j);
        logic [4:0] s;
        case (j / 16)
            0:
            begin
                case (j % 4)
                    0:       s = 5'd3;
                    1:       s = 5'd7;
                    2:       s = 5'd11;
                    default: s = 5'd19;
                endcase
            end
            1:
            begin
                case (j % 4)
                    0:       s = 5'd3;
                    1:       s = 5'd5;
                    2:       s = 5'd9;
                    default: s = 5'd13;
                endcase
            end
            default:
            begin
                case (j % 4)
                    0:       s = 5'd3;
                    1:       s = 5'd9;
                    2:       s = 5'd11;
                    default: s = 5'd15;
                endcase
            end
        endcase
        return s;
    endfunction

    function automatic void compress_block();
        logic [31:0] v [4];
        logic [31:0] x, y, z, f, k;
        logic [1:0]  t;
        int          j;
        for (j = 0; j < 4; j++)
            v[j] = chain_st[j];
        for (j = 0; j < 48; j++)
        begin
            // target word rotates a, d, c, b
            t = 2'(4 - (j % 4));
            x = v[2'(t + 1)];
            y = v[2'(t + 2)];
            z = v[2'(t + 3)];
            if (j < 16)
            begin
                f = (x & y) | (~x & z);
                k = 32'h0;
            end
            else if (j < 32)
            begin
                f = (x & y) | (x & z) | (y & z);
                k = md4_pkg::RK2;
            end
            else
            begin
                f = x ^ y ^ z;
                k = md4_pkg::RK3;
            end
            v[t] = rotl(v[t] + f + block_st[word_for_round(j)] + k, shift_for_round(j));
        end
        for (j = 0; j < 4; j++)
            chain_st[j] = chain_st[j] + v[j];
    endfunction

    function automatic void put_byte(input logic [5:0] pos, input logic [7:0] b);
        block_st[pos[5:2]][{pos[1:0], 3'b000} +: 8] = b;
        if (pos == md4_pkg::OFS_MASK)
            compress_block();
    endfunction

    function automatic void restart_chain();
        chain_st[0] = md4_pkg::IV0;
        chain_st[1] = md4_pkg::IV1;
        chain_st[2] = md4_pkg::IV2;
        chain_st[3] = md4_pkg::IV3;
        msg_bytes   = 64'h0;
    endfunction

    function automatic void absorb_word(input logic [31:0] data, input logic [2:0] nb,
                                        input logic fin);
        int          n;
        int          i;
        logic [5:0]  p;
        logic [63:0] bits;
        digest_beat_t beat;
        // counts above four saturate
        n = (nb > md4_pkg::MAX_BYTES) ? int'(md4_pkg::MAX_BYTES) : int'(nb);
        for (i = 0; i < n; i++)
        begin
            put_byte(msg_bytes[5:0], data[8*i +: 8]);
            msg_bytes = msg_bytes + 64'd1;
        end
        if (fin)
        begin
            p = msg_bytes[5:0];
            put_byte(p, md4_pkg::PAD_BYTE);
            p = p + 6'd1;
            while (p != md4_pkg::LEN_OFS)
            begin
                put_byte(p, 8'h00);
                p = p + 6'd1;
            end
            bits = msg_bytes << 3;
            for (i = 0; i < 8; i++)
                put_byte(md4_pkg::LEN_OFS + 6'(i), bits[8*i +: 8]);
            for (i = 0; i < 4; i++)
            begin
                beat.word  = chain_st[i];
                beat.index = 2'(i);
                beat.last  = (i == 3);
                digest_due.push_back(beat);
            end
            restart_chain();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_chain();
            digest_due.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (msg.valid && msg.ready)
                absorb_word(msg.data_word, msg.valid_bytes, msg.final_word);
            if (digest.valid && digest.ready)
            begin
                if (digest_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: digest beat with none expected: word %h index %0d end %b",
                             $time, digest.digest_word, digest.word_index, digest.digest_end);
                end
                else
                begin
                    due = digest_due.pop_front();
                    if (digest.digest_word !== due.word)
                    begin
                        errors++;
                        $display("%0t: digest_word (index %0d) expected %h actual %h",
                                 $time, due.index, due.word, digest.digest_word);
                    end
                    if (digest.word_index !== due.index)
                    begin
                        errors++;
                        $display("%0t: word_index expected %0d actual %0d",
                                 $time, due.index, digest.word_index);
                    end
                    if (digest.digest_end !== due.last)
                    begin
                        errors++;
                        $display("%0t: digest_end (index %0d) expected %b actual %b",
                                 $time, due.index, due.last, digest.digest_end);
                    end
                end
            end
            pending = digest_due.size();
        end
    end

endmodule

/* tb/md4_hash_engine_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md4_hash_engine_tb
// Drives messages into the MD4 engine: a few fixed messages covering byte
// counts, saturation, empty and short words, then random messages of short,
// near-boundary and multi-block sizes, with random gaps on both channels. The
// checker beside the engine predicts and compares the digests.
// ----------------------------------------------------------------------------
module md4_hash_engine_tb;

    localparam int MSG_ITEMS    = 360;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 120;

    logic clk = 1'b0;
    logic rst_n;
    bit   burst_mode;
    int   items_sent;
    int   idle_cycles = 0;
    int   errors;
    int   pending;

    md4_in_if  msg_ch ();
    md4_out_if dig_ch ();

    md4_hash_engine dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .digest (dig_ch)
    );

    md4_digest_checker digest_chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .msg     (msg_ch),
        .digest  (dig_ch),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // mostly no gap or a short one, now and then a long one
    function automatic int gap_len();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic send_word(input logic [31:0] data, input logic [2:0] nb, input logic fin);
        int gap;
        gap = gap_len();
        @(negedge clk);
        if (gap > 0)
        begin
            msg_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        msg_ch.valid       <= 1'b1;
        msg_ch.data_word   <= data;
        msg_ch.valid_bytes <= nb;
        msg_ch.final_word  <= fin;
        @(posedge clk);
        while (!msg_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // digest side back-pressure
    initial
    begin
        int stall;
        stall = 0;
        dig_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                dig_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                dig_ch.ready <= 1'b1;
                stall = gap_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int  r;
        int  nwords;
        int  nb;
        bit  noisy;
        rst_n              = 1'b0;
        burst_mode         = 1'b0;
        items_sent         = 0;
        msg_ch.valid       = 1'b0;
        msg_ch.data_word   = 32'h0;
        msg_ch.valid_bytes = 3'd0;
        msg_ch.final_word  = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_word(32'h0000_0000, 3'd0, 1'b1);   // empty message
        send_word(32'h0063_6261, 3'd3, 1'b1);   // "abc"
        send_word(32'hdead_be61, 3'd1, 1'b1);   // junk above the valid byte
        send_word(32'hffff_ffff, 3'd4, 1'b1);
        send_word(32'h0000_0000, 3'd4, 1'b1);
        send_word(32'h1234_5678, 3'd7, 1'b1);   // saturating count on a final beat
        // short, empty and saturating beats mid-message
        send_word(32'ha5a5_a5a5, 3'd3, 1'b0);
        send_word(32'hffff_ffff, 3'd0, 1'b0);
        send_word(32'h8765_4321, 3'd5, 1'b0);
        send_word(32'h0000_beef, 3'd2, 1'b0);
        send_word(32'hcafe_f00d, 3'd1, 1'b0);
        send_word(32'hffff_ffff, 3'd6, 1'b1);
        // zero-length message spread over two beats
        send_word(32'h5555_aaaa, 3'd0, 1'b0);
        send_word(32'hffff_ffff, 3'd0, 1'b1);

        while (items_sent < MSG_ITEMS)
        begin
            r          = $urandom_range(0, 99);
            burst_mode = ($urandom_range(0, 4) == 0);
            noisy      = ($urandom_range(0, 9) == 0);
            if (r < 35)
                nwords = $urandom_range(0, 6);
            else if (r < 80)
                nwords = $urandom_range(12, 16);   // final lands near the length field
            else
                nwords = $urandom_range(17, 34);
            repeat (nwords)
            begin
                if (noisy || $urandom_range(0, 9) == 0)
                    nb = $urandom_range(0, 7);
                else
                    nb = 4;
                send_word($urandom(), 3'(nb), 1'b0);
            end
            send_word($urandom(), 3'($urandom_range(0, 7)), 1'b1);
        end
        burst_mode = 1'b0;

        @(negedge clk);
        msg_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
sv/md4_pkg.sv
sv/md4_in_if.sv
sv/md4_out_if.sv
sv/md4_dpath.sv
sv/md4_ctrl.sv
sv/md4_hash_engine.sv
sv/md4_chk.sv
tb/md4_digest_checker.sv
tb/md4_hash_engine_tb.sv
